// ----- src/scba_pkg.sv -----
// Shared constants, codes and control/status types for the size-class block allocator.
package scba_pkg;

	// Default sizing of the class table and link memory
	localparam int MAX_CLASSES_DEF = 8;
	localparam int MAX_BLOCKS_DEF  = 256;

	// Stream payload widths
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 32;

	// Register reset values
	localparam logic [15:0] MIN_SIZE_RST = 16'd64;
	localparam logic [15:0] MAX_SIZE_RST = 16'd1024;
	localparam logic [11:0] FACTOR_RST   = 12'd512;
	localparam logic [8:0]  BLOCKS_RST   = 9'd256;

	// Register indexes
	localparam logic [1:0] REG_MIN_SIZE = 2'd0;
	localparam logic [1:0] REG_MAX_SIZE = 2'd1;
	localparam logic [1:0] REG_FACTOR   = 2'd2;
	localparam logic [1:0] REG_BLOCKS   = 2'd3;

	// Request kinds
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_OOM        = 2'd1;
	localparam logic [1:0] ST_BAD_HANDLE = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic size_init;
		logic size_step;
		logic clear_step;
		logic accept;
		logic eval;
		logic pick;
		logic read_link;
		logic div_step;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic size_last;
		logic clear_last;
		logic is_free;
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

// ----- src/scba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module scba_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/scba_ctrl.sv -----
// Controller state machine: init sequence, item sequencing and result handoff.
module scba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           in_valid,
	output logic           in_ready,
	input  scba_pkg::stat_t stat,
	output scba_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_START,
		S_SIZE,
		S_CLEAR,
		S_IDLE,
		S_EVAL,
		S_PICK,
		S_READ,
		S_DIV,
		S_COMMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ready_q;

	// Next state; any register write restarts the table build
	always_comb begin
		state_d = state_q;
		if (cfg_we) begin
			state_d = S_START;
		end else begin
			case (state_q)
				S_START:  state_d = S_SIZE;
				S_SIZE:   if (stat.size_last) state_d = S_CLEAR;
				S_CLEAR:  if (stat.clear_last) state_d = S_IDLE;
				S_IDLE:   if (in_valid) state_d = S_EVAL;
				S_EVAL:   state_d = stat.is_free ? S_DIV : S_PICK;
				S_PICK:   state_d = S_READ;
				S_READ:   state_d = S_COMMIT;
				S_DIV:    if (stat.div_last) state_d = S_COMMIT;
				S_COMMIT: if (stat.out_free) state_d = S_IDLE;
				default:  state_d = S_START;
			endcase
		end
	end

	// State and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_START;
			ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == S_IDLE);
		end
	end

	assign in_ready = ready_q;

	// Datapath commands
	always_comb begin
		cmd            = '0;
		cmd.size_init  = (state_q == S_START);
		cmd.size_step  = (state_q == S_SIZE);
		cmd.clear_step = (state_q == S_CLEAR);
		cmd.accept     = (state_q == S_IDLE) && ready_q && in_valid;
		cmd.eval       = (state_q == S_EVAL);
		cmd.pick       = (state_q == S_PICK);
		cmd.read_link  = (state_q == S_READ);
		cmd.div_step   = (state_q == S_DIV);
		cmd.commit     = (state_q == S_COMMIT) && stat.out_free;
	end

endmodule

// ----- src/scba_dp.sv -----
// Datapath: registers, class table, free list heads and counts, handle divider, link memory.
module scba_dp #(
	parameter int MAX_CLASSES = scba_pkg::MAX_CLASSES_DEF,
	parameter int MAX_BLOCKS  = scba_pkg::MAX_BLOCKS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  scba_pkg::cmd_t  cmd,
	output scba_pkg::stat_t stat,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data,
	input  logic            in_action,
	input  logic [15:0]     in_need,
	input  logic [11:0]     in_handle,
	input  logic            out_ready,
	output logic            out_valid,
	output logic [11:0]     out_handle,
	output logic [15:0]     out_size,
	output logic [1:0]      out_status
);

	localparam int CW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int TW    = $clog2(MAX_CLASSES + 1);
	localparam int BW    = $clog2(MAX_BLOCKS + 1);
	localparam int IW    = $clog2(MAX_BLOCKS);
	localparam int DEPTH = MAX_CLASSES * MAX_BLOCKS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = (CW > 1) ? $clog2(CW) : 1;
	localparam int CAPW  = TW + BW;
	localparam int CMPW  = (CAPW > 12) ? CAPW : 12;
	localparam int DW    = (BW + CW > 12) ? BW + CW : 12;
	localparam int HSW   = CW + BW + 2;

	// Configuration registers
	logic [15:0] min_q;
	logic [15:0] max_q;
	logic [11:0] fac_q;
	logic [8:0]  blk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= scba_pkg::MIN_SIZE_RST;
			max_q <= scba_pkg::MAX_SIZE_RST;
			fac_q <= scba_pkg::FACTOR_RST;
			blk_q <= scba_pkg::BLOCKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				scba_pkg::REG_MIN_SIZE: min_q <= cfg_data;
				scba_pkg::REG_MAX_SIZE: max_q <= cfg_data;
				scba_pkg::REG_FACTOR:   fac_q <= cfg_data[11:0];
				scba_pkg::REG_BLOCKS:   blk_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Effective blocks per class: zero acts as one, clipped to the memory row
	logic [BW-1:0] eff_b;
	always_comb begin
		if (blk_q == 9'd0) begin
			eff_b = BW'(1);
		end else if (32'(blk_q) > 32'(MAX_BLOCKS)) begin
			eff_b = BW'(MAX_BLOCKS);
		end else begin
			eff_b = BW'(blk_q);
		end
	end

	// Class table state
	logic [15:0]   size_q [MAX_CLASSES];
	logic [TW-1:0] total_q;
	logic [19:0]   n_q;
	logic [CW-1:0] cnt_q;
	logic [CAPW-1:0] cap_q;

	// Free list state
	logic [BW-1:0] head_q   [MAX_CLASSES];
	logic [BW-1:0] fcount_q [MAX_CLASSES];

	// Clearing sweep
	logic [AW-1:0] clr_addr_q;
	logic [IW-1:0] clr_idx_q;

	// Current item
	logic          act_q;
	logic [15:0]   need_q;
	logic [11:0]   hdl_q;
	logic [MAX_CLASSES-1:0] fit_q;
	logic [MAX_CLASSES-1:0] low_q;
	logic [CW-1:0] sel_q;
	logic          found_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] q_q;
	logic [SW-1:0] step_q;
	logic          bad_q;

	// Output register
	logic          out_valid_q;
	logic [11:0]   out_handle_q;
	logic [15:0]   out_size_q;
	logic [1:0]    out_status_q;

	// Size growth step: one multiply per class, registered in n_q
	logic [27:0] prod;
	logic [19:0] grown;
	logic [19:0] n_inc;
	logic [19:0] n_next;
	logic        size_go;

	assign prod    = n_q[15:0] * fac_q;
	assign grown   = prod[27:8];
	assign n_inc   = n_q + 20'd1;
	assign n_next  = (grown > n_inc) ? grown : n_inc;
	assign size_go = (n_q < {4'd0, max_q}) && (32'(cnt_q) < 32'(MAX_CLASSES - 1));

	// Class availability flags
	logic [MAX_CLASSES-1:0] fit_d;
	logic [MAX_CLASSES-1:0] low_d;
	always_comb begin
		for (int c = 0; c < MAX_CLASSES; c++) begin
			logic live;
			live = (TW'(c) < total_q) && (fcount_q[c] != '0) && (head_q[c] < eff_b);
			fit_d[c] = live && (size_q[c] >= need_q);
			low_d[c] = live && (size_q[c] < need_q);
		end
	end

	// Pick: smallest fitting class, else the largest smaller one
	logic [CW-1:0] sel_d;
	logic          found_d;
	always_comb begin
		sel_d   = '0;
		found_d = (|fit_q) || (|low_q);
		if (|fit_q) begin
			for (int c = MAX_CLASSES - 1; c >= 0; c--) begin
				if (fit_q[c]) sel_d = CW'(c);
			end
		end else begin
			for (int c = 0; c < MAX_CLASSES; c++) begin
				if (low_q[c]) sel_d = CW'(c);
			end
		end
	end

	// Divider trial subtract
	logic [DW-1:0] dv;
	assign dv = DW'(eff_b) << step_q;

	// Free acceptance and allocated handle
	logic           ok_free;
	logic [HSW-1:0] alloc_hdl;
	assign ok_free   = !bad_q && (fcount_q[q_q] < eff_b);
	assign alloc_hdl = HSW'(sel_q) * HSW'(eff_b) + HSW'(head_q[sel_q]) + HSW'(1);

	// Link memory ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [BW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [BW-1:0] ram_rdata;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_addr_q;
		ram_wdata = BW'(clr_idx_q) + BW'(1);
		if (cmd.clear_step) begin
			ram_we = 1'b1;
		end else if (cmd.commit && act_q == scba_pkg::ACT_FREE && ok_free) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(32'(q_q) * MAX_BLOCKS) + AW'(rem_q[IW-1:0]);
			ram_wdata = head_q[q_q];
		end
	end

	assign ram_re    = cmd.read_link && found_q;
	assign ram_raddr = AW'(32'(sel_q) * MAX_BLOCKS) + AW'(head_q[sel_q]);

	scba_ram #(
		.WIDTH(BW),
		.DEPTH(DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Table build, sweep, item datapath and free list updates
	always_ff @(posedge clk) begin
		cap_q <= CAPW'(total_q) * CAPW'(eff_b);

		if (cmd.size_init) begin
			for (int c = 0; c < MAX_CLASSES; c++) begin
				size_q[c]   <= '0;
				head_q[c]   <= '0;
				fcount_q[c] <= eff_b;
			end
			n_q        <= {4'd0, min_q};
			cnt_q      <= '0;
			clr_addr_q <= '0;
			clr_idx_q  <= '0;
		end

		if (cmd.size_step) begin
			if (size_go) begin
				size_q[cnt_q] <= n_q[15:0];
				n_q           <= n_next;
				cnt_q         <= cnt_q + CW'(1);
			end else begin
				size_q[cnt_q] <= max_q;
				total_q       <= TW'(cnt_q) + TW'(1);
			end
		end

		if (cmd.clear_step) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			clr_idx_q  <= (clr_idx_q == IW'(MAX_BLOCKS - 1)) ? '0 : clr_idx_q + IW'(1);
		end

		if (cmd.accept) begin
			act_q  <= in_action;
			need_q <= in_need;
			hdl_q  <= in_handle;
		end

		if (cmd.eval) begin
			fit_q  <= fit_d;
			low_q  <= low_d;
			rem_q  <= DW'(hdl_q - 12'd1);
			bad_q  <= (hdl_q == 12'd0) || (CMPW'(hdl_q) > CMPW'(cap_q));
			q_q    <= '0;
			step_q <= SW'(CW - 1);
		end

		if (cmd.pick) begin
			sel_q   <= sel_d;
			found_q <= found_d;
		end

		// One quotient bit a step, restoring
		if (cmd.div_step) begin
			if (rem_q >= dv) begin
				rem_q         <= rem_q - dv;
				q_q[step_q]   <= 1'b1;
			end
			step_q <= step_q - SW'(1);
		end

		if (cmd.commit) begin
			out_handle_q <= '0;
			out_size_q   <= '0;
			if (act_q == scba_pkg::ACT_ALLOC) begin
				if (found_q) begin
					head_q[sel_q]   <= ram_rdata;
					fcount_q[sel_q] <= fcount_q[sel_q] - BW'(1);
					out_handle_q    <= 12'(alloc_hdl);
					out_size_q      <= size_q[sel_q];
					out_status_q    <= scba_pkg::ST_OK;
				end else begin
					out_status_q <= scba_pkg::ST_OOM;
				end
			end else begin
				if (ok_free) begin
					head_q[q_q]   <= BW'(rem_q);
					fcount_q[q_q] <= fcount_q[q_q] + BW'(1);
					out_status_q  <= scba_pkg::ST_OK;
				end else begin
					out_status_q <= scba_pkg::ST_BAD_HANDLE;
				end
			end
		end
	end

	// Result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_handle = out_handle_q;
	assign out_size   = out_size_q;
	assign out_status = out_status_q;

	// Status to the controller
	always_comb begin
		stat            = '0;
		stat.size_last  = !size_go;
		stat.clear_last = (clr_addr_q == AW'(DEPTH - 1));
		stat.is_free    = (act_q == scba_pkg::ACT_FREE);
		stat.div_last   = (step_q == '0);
		stat.out_free   = !out_valid_q || out_ready;
	end

endmodule

// ----- src/size_class_block_allocator.sv -----
// Top level of the size-class block allocator.
//
// Hands out 1-based block handles from up to MAX_CLASSES geometric size
// classes, each a LIFO free list of up to MAX_BLOCKS blocks kept in a link RAM.
// s_axis: one request per beat; tuser is the kind (0 allocate, 1 free).
// m_axis: one result beat per request: handle, granted size and status.
// cfg: register writes (index, data), always ready; each write rebuilds the
// class table and all free lists, so it is meant for an idle block.
// Timing: one request at a time. An allocate steps through evaluate, pick,
// link RAM read and commit; a free steps through evaluate, the
// one-bit-per-cycle handle divider and commit. The result beat appears
// the cycle after commit.
// Reset and every register write: the class table is built one class per
// cycle, then the link RAM is swept one entry per cycle over all
// MAX_CLASSES*MAX_BLOCKS entries; s_axis_tready stays low meanwhile.
// A stalled result beat holds in the output register; the next request is
// still accepted and waits at commit until the result slot frees.
module size_class_block_allocator #(
	parameter int MAX_CLASSES = scba_pkg::MAX_CLASSES_DEF,
	parameter int MAX_BLOCKS  = scba_pkg::MAX_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // need_size[15:0], handle[27:16], zero[31:28]
	input  logic        s_axis_tuser,  // action[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // result_handle[11:0], granted_size[27:12], zero[31:28]
	output logic [1:0]  m_axis_tuser,  // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	scba_pkg::cmd_t  cmd;
	scba_pkg::stat_t stat;
	logic            cfg_we;
	logic [11:0]     res_handle;
	logic [15:0]     res_size;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	scba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	scba_dp #(
		.MAX_CLASSES(MAX_CLASSES),
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_action (s_axis_tuser),
		.in_need   (s_axis_tdata[15:0]),
		.in_handle (s_axis_tdata[27:16]),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_handle(res_handle),
		.out_size  (res_size),
		.out_status(m_axis_tuser)
	);

	assign m_axis_tdata = {4'd0, res_size, res_handle};

endmodule

// ----- src/scba_checker.sv -----
// Port-level checks for the allocator, bound to the top level.
module scba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// A stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// One request in flight: ready drops after an accepted beat
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request accepted back to back");

	// Failures carry no handle and no size
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == scba_pkg::ST_OOM
			|| m_axis_tuser == scba_pkg::ST_BAD_HANDLE)
		|-> m_axis_tdata[27:0] == 28'd0)
		else $error("failed result carries a handle or size");

	// A granted handle comes with ok status and a nonzero size
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[11:0] != 12'd0
		|-> m_axis_tuser == scba_pkg::ST_OK && m_axis_tdata[27:12] != 16'd0)
		else $error("handle granted without ok status");

	// No status code beyond bad handle
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("undefined status code");

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the size-class block allocator: directed table, then random load.
module tb_top;

	localparam int NCLS = scba_pkg::MAX_CLASSES_DEF;
	localparam int NBLK = scba_pkg::MAX_BLOCKS_DEF;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [11:0] handle;
		logic [15:0] size;
		logic [1:0]  status;
	} grant_t;

	// one directed row: a request beat or a register write
	typedef struct {
		bit          is_cfg;
		logic        act;
		logic [15:0] size;   // need size, or register data
		logic [11:0] handle; // handle, or register index
		bit          typed;
		grant_t      want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	size_class_block_allocator dut (.*);

	always #5 clk = ~clk;

	// allocator shadow state
	logic [15:0] min_sz, max_sz;
	logic [11:0] factor;
	logic [8:0]  blocks_reg;
	logic [8:0]  link_ram [NCLS*NBLK];
	logic [8:0]  head [NCLS];
	logic [8:0]  avail [NCLS];
	logic [15:0] csize [NCLS];
	int          ncls;

	grant_t grants_due[$];
	grant_t typed_due[$];
	logic [11:0] held[$];
	int errors = 0;
	int mode = 0;      // 0 none, 1 sender idle, 2 receiver stall, 3 both
	int quiet = 0;

	function automatic int blk_count();
		if (blocks_reg == 0) return 1;
		if (blocks_reg > NBLK) return NBLK;
		return blocks_reg;
	endfunction

	// recompute class table and free every block
	function automatic void build_classes();
		int n, grown;
		n = min_sz;
		ncls = 0;
		while (n < max_sz && ncls < NCLS - 1) begin
			csize[ncls] = 16'(n);
			ncls++;
			grown = (n * factor) >> 8;
			n = (grown > n + 1) ? grown : n + 1;
		end
		csize[ncls] = max_sz;
		ncls++;
		for (int c = 0; c < NCLS; c++) begin
			head[c] = '0;
			avail[c] = 9'(blk_count());
			for (int i = 0; i < NBLK; i++) link_ram[c*NBLK + i] = 9'(i + 1);
			if (c >= ncls) csize[c] = '0;
		end
		held.delete();
	endfunction

	function automatic void write_reg(logic [1:0] idx, logic [15:0] val);
		case (idx)
			scba_pkg::REG_MIN_SIZE: min_sz = val;
			scba_pkg::REG_MAX_SIZE: max_sz = val;
			scba_pkg::REG_FACTOR:   factor = val[11:0];
			scba_pkg::REG_BLOCKS:   blocks_reg = val[8:0];
			default: ;
		endcase
		build_classes();
	endfunction

	function automatic bit pop_block(int c, output grant_t g);
		int b, h;
		g = '0;
		b = blk_count();
		h = head[c];
		if (avail[c] == 0 || h >= b) return 0;
		head[c] = link_ram[c*NBLK + h];
		avail[c]--;
		g.handle = 12'(c * b + h + 1);
		g.size = csize[c];
		g.status = scba_pkg::ST_OK;
		return 1;
	endfunction

	function automatic grant_t serve(logic act, logic [15:0] need, logic [11:0] hnd);
		grant_t g;
		int b, c, idx;
		g = '0;
		b = blk_count();
		if (act == scba_pkg::ACT_ALLOC) begin
			for (c = 0; c < ncls; c++)
				if (csize[c] >= need && pop_block(c, g)) return g;
			for (c = ncls - 1; c >= 0; c--)
				if (csize[c] < need && pop_block(c, g)) return g;
			g.status = scba_pkg::ST_OOM;
			return g;
		end
		if (hnd == 0 || hnd > ncls * b) begin
			g.status = scba_pkg::ST_BAD_HANDLE;
			return g;
		end
		c = (hnd - 1) / b;
		idx = (hnd - 1) % b;
		if (avail[c] >= b) begin
			g.status = scba_pkg::ST_BAD_HANDLE;
			return g;
		end
		link_ram[c*NBLK + idx] = head[c];
		head[c] = 9'(idx);
		avail[c]++;
		return g;
	endfunction

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		$display("ERROR @%0t: %s got %0d want %0d", $time, what, got, want);
		errors++;
	endtask

	// accepted requests and register writes feed the shadow model
	always @(posedge clk) begin
		grant_t g;
		if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
		if (s_axis_tvalid && s_axis_tready) begin
			g = serve(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[27:16]);
			if (typed_due.size() != 0) g = typed_due.pop_front();
			if (g.status == scba_pkg::ST_OK && s_axis_tuser == scba_pkg::ACT_ALLOC)
				held.insert(held.size(), g.handle);
			grants_due.insert(grants_due.size(), g);
		end
	end

	// result beats checked against the oldest expectation
	always @(posedge clk) begin
		grant_t w;
		if (m_axis_tvalid && m_axis_tready) begin
			if (grants_due.size() == 0) begin
				report("beat with nothing pending, handle", 16'(m_axis_tdata[11:0]), 16'd0);
			end else begin
				w = grants_due.pop_front();
				if (m_axis_tdata[11:0] !== w.handle) report("handle", m_axis_tdata[11:0], w.handle);
				if (m_axis_tdata[27:12] !== w.size) report("size", m_axis_tdata[27:12], w.size);
				if (m_axis_tuser !== w.status) report("status", m_axis_tuser, w.status);
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (mode == 2) m_axis_tready <= ($urandom_range(99) >= 69);
		else if (mode == 3) m_axis_tready <= ($urandom_range(99) >= 16);
		else m_axis_tready <= 1'b1;
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic drain();
		wait (grants_due.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_all(logic [15:0] mn, logic [15:0] mx, logic [15:0] fa, logic [15:0] bl);
		drain();
		cfg_write(scba_pkg::REG_MIN_SIZE, mn);
		cfg_write(scba_pkg::REG_MAX_SIZE, mx);
		cfg_write(scba_pkg::REG_FACTOR, fa);
		cfg_write(scba_pkg::REG_BLOCKS, bl);
	endtask

	// one request beat; valid stays high and drops only when the next send idles first or idle_in is called
	task automatic send(logic act, logic [15:0] need, logic [11:0] hnd);
		@(negedge clk);
		while ((mode == 1 && $urandom_range(99) < 69) || (mode == 3 && $urandom_range(99) < 16)) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = act;
		s_axis_tdata = {4'b0, hnd, need};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic idle_in();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	function automatic logic [15:0] pick_need();
		int r, c;
		r = $urandom_range(99);
		c = $urandom_range(ncls - 1);
		if (r < 45) return 16'(csize[c] + $urandom_range(2) - 1);
		if (r < 65) return 16'($urandom);
		return 16'($urandom_range(csize[ncls-1]));
	endfunction

	function automatic logic [11:0] pick_handle();
		int r, k;
		r = $urandom_range(99);
		if (r < 55 && held.size() != 0) begin
			k = $urandom_range(held.size() - 1);
			pick_handle = held[k];
			held.delete(k);
			return pick_handle;
		end
		if (r < 70) return 12'($urandom_range(ncls * blk_count() + 1));
		return 12'($urandom);
	endfunction

	row_t plan[$];

	function automatic row_t mk(bit cfgr, logic act, int sz, int hnd, bit typed,
			int wh = 0, int ws = 0, logic [1:0] wst = scba_pkg::ST_OK);
		row_t r;
		r.is_cfg = cfgr;
		r.act = act;
		r.size = 16'(sz);
		r.handle = 12'(hnd);
		r.typed = typed;
		r.want = '{handle: 12'(wh), size: 16'(ws), status: wst};
		return r;
	endfunction

	initial begin
		int n_items;
		min_sz = scba_pkg::MIN_SIZE_RST;
		max_sz = scba_pkg::MAX_SIZE_RST;
		factor = scba_pkg::FACTOR_RST;
		blocks_reg = scba_pkg::BLOCKS_RST;
		build_classes();

		// after reset the classes are 64, 128, 256, 512, 1024
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_ALLOC, 0, 0, 1, 1, 64));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_ALLOC, 64, 0, 1, 2, 64));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_ALLOC, 65, 0, 1, 257, 128));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_ALLOC, 65535, 0, 1, 1025, 1024));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_FREE, 0, 0, 1, 0, 0,
			scba_pkg::ST_BAD_HANDLE));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_FREE, 0, 4095, 1, 0, 0,
			scba_pkg::ST_BAD_HANDLE));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_FREE, 0, 1281, 1, 0, 0,
			scba_pkg::ST_BAD_HANDLE));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_FREE, 65535, 1, 1, 0, 0,
			scba_pkg::ST_OK));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_FREE, 0, 1, 0));  // double free links twice
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_ALLOC, 1, 0, 0));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_ALLOC, 1, 0, 0));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_FREE, 0, 1280, 0)); // never allocated
		// one class of one block, size 9
		plan.insert(plan.size(), mk(1, 0, 9, scba_pkg::REG_MIN_SIZE, 0));
		plan.insert(plan.size(), mk(1, 0, 9, scba_pkg::REG_MAX_SIZE, 0));
		plan.insert(plan.size(), mk(1, 0, 256, scba_pkg::REG_FACTOR, 0));
		plan.insert(plan.size(), mk(1, 0, 1, scba_pkg::REG_BLOCKS, 0));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_ALLOC, 65535, 0, 1, 1, 9));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_ALLOC, 9, 0, 1, 0, 0,
			scba_pkg::ST_OOM));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_FREE, 0, 2, 1, 0, 0,
			scba_pkg::ST_BAD_HANDLE));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_FREE, 0, 1, 1, 0, 0,
			scba_pkg::ST_OK));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_FREE, 0, 1, 1, 0, 0,
			scba_pkg::ST_BAD_HANDLE));
		// max below min, blocks 0 acts as one
		plan.insert(plan.size(), mk(1, 0, 65535, scba_pkg::REG_MIN_SIZE, 0));
		plan.insert(plan.size(), mk(1, 0, 0, scba_pkg::REG_BLOCKS, 0));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_ALLOC, 10, 0, 1, 1, 9));
		plan.insert(plan.size(), mk(0, scba_pkg::ACT_ALLOC, 0, 0, 1, 0, 0,
			scba_pkg::ST_OOM));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				idle_in();
				drain();
				cfg_write(plan[i].handle[1:0], plan[i].size);
			end else begin
				if (plan[i].typed) typed_due.insert(typed_due.size(), plan[i].want);
				send(plan[i].act, plan[i].size, plan[i].handle);
			end
		end
		idle_in();

		// random phases over several settings
		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: set_all(scba_pkg::MIN_SIZE_RST, scba_pkg::MAX_SIZE_RST,
					16'(scba_pkg::FACTOR_RST), 16'(scba_pkg::BLOCKS_RST));
				1: set_all(9, 65535, 256, 1);
				2: set_all(9, 65535, 4095, 511);
				3: set_all(65535, 9, 300, 0);
				4: set_all(100, 200, 256, 4);
				5: set_all(9, 9, 4095, 3);
				6: set_all(1000, 60000, 700, 8);
				7: set_all(65535, 65535, 256, 256);
				default: set_all(16'($urandom_range(9, 2000)), 16'($urandom_range(9, 65535)),
					16'($urandom_range(256, 4095)), 16'($urandom_range(1, 12)));
			endcase
			mode = ph % 4;
			n_items = 100 + $urandom_range(10);
			for (int k = 0; k < n_items; k++) begin
				if (k == 50 && (ph % 3) == 0) begin
					idle_in();
					wait (grants_due.size() == 0);
				end
				if ($urandom_range(99) < 60)
					send(scba_pkg::ACT_ALLOC, pick_need(), 12'($urandom));
				else
					send(scba_pkg::ACT_FREE, 16'($urandom), pick_handle());
			end
			idle_in();
		end

		mode = 0;
		wait (grants_due.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
